// ===== rtl/core/minimum_spanning_tree_prim_defines.svh =====
// Assertion macros for the Prim spanning tree engine.
`ifndef MINIMUM_SPANNING_TREE_PRIM_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_PRIM_DEFINES_SVH

// Invariant checked at every rising clock edge outside reset.
`define MSTP_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define MSTP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/mstp_pkg.sv =====
// Shared constants and types for the Prim spanning tree engine.
package mstp_pkg;

  localparam int NODE_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 1'b1;

  localparam logic [NODE_W-1:0] NODE_TOTAL_RST = 7'd64;
  localparam logic [NODE_W-1:0] ROOT_NODE_RST  = 7'd1;

  typedef struct packed {
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } node_pair_t;

  typedef struct packed {
    logic       found;
    node_pair_t pair;
  } best_stat_t;

endpackage

// ===== rtl/core/mstp_edge_store.sv =====
// Edge store memory: one write port, one registered read port.
module mstp_edge_store #(
  parameter int DEPTH       = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [mstp_pkg::NODE_W-1:0]                 wr_a,
  input  logic [mstp_pkg::NODE_W-1:0]                 wr_b,
  input  logic signed [WEIGHT_BITS-1:0]               wr_w,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [mstp_pkg::NODE_W-1:0]                 rd_a,
  output logic [mstp_pkg::NODE_W-1:0]                 rd_b,
  output logic signed [WEIGHT_BITS-1:0]               rd_w
);

  localparam int DW = 2 * mstp_pkg::NODE_W + WEIGHT_BITS;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_a, wr_b, wr_w};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_a = rd_data_r[DW-1 -: mstp_pkg::NODE_W];
  assign rd_b = rd_data_r[WEIGHT_BITS +: mstp_pkg::NODE_W];
  assign rd_w = rd_data_r[WEIGHT_BITS-1:0];

endmodule

// ===== rtl/core/mstp_min_unit.sv =====
// Shared compare unit: keeps the smallest (weight, from, to) candidate of a scan.
module mstp_min_unit #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          cand_vld,
  input  mstp_pkg::node_pair_t          cand_pair,
  input  logic signed [WEIGHT_BITS-1:0] cand_w,
  output mstp_pkg::best_stat_t          best,
  output logic signed [WEIGHT_BITS-1:0] best_w
);

  logic                          found_r;
  mstp_pkg::node_pair_t          pair_r;
  logic signed [WEIGHT_BITS-1:0] w_r;
  logic                          less;
  logic                          take;

  always_comb begin
    less = (cand_w < w_r) || ((cand_w == w_r) && (cand_pair < pair_r));
    take = cand_vld && (!found_r || less);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr && take) begin
      pair_r <= cand_pair;
      w_r    <= cand_w;
    end
  end

  assign best.found = found_r;
  assign best.pair  = pair_r;
  assign best_w     = w_r;

endmodule

// ===== rtl/core/minimum_spanning_tree_prim.sv =====
// An edge without last_edge is taken while idle, one per cycle.
// The last edge starts a run of (tree edges + 1) rounds; in each round the
// scan feeds one edge store read per cycle to the shared compare unit.
// A root out of range skips the scan and goes straight to closing the run.
// in_ready is low for the whole run; the final result may wait at the output.
// Synchronous reset clears the fill count, drop flag, visited map and config
// (node_total 64, root_node 1); the edge store itself is not cleared.
module minimum_spanning_tree_prim #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mstp_pkg::NODE_W-1:0]        in_end_a,
  input  logic [mstp_pkg::NODE_W-1:0]        in_end_b,
  input  logic signed [WEIGHT_BITS-1:0]      in_edge_weight,
  input  logic                               in_last_edge,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mstp_pkg::NODE_W-1:0]        out_from_node,
  output logic [mstp_pkg::NODE_W-1:0]        out_to_node,
  output logic signed [WEIGHT_BITS-1:0]      out_tree_weight,
  output logic                               out_edge_valid,
  output logic                               out_last_result,
  output logic                               out_dropped_edges,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mstp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mstp_pkg::NODE_W-1:0]        cfg_data
);

`include "minimum_spanning_tree_prim_defines.svh"

  localparam int NW = mstp_pkg::NODE_W;
  localparam int FW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int IW = $clog2(MAX_NODES);
  localparam logic [NW-1:0] MAX_NODE_VAL = NW'(MAX_NODES);
  localparam logic [NW-1:0] NODE_ONE     = NW'(1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [NW-1:0]                 node_total_r, root_node_r;
  logic [FW-1:0]                 fill_r, fill_nxt;
  logic [FW-1:0]                 scan_cnt_r, scan_cnt_nxt;
  logic                          drop_r, drop_nxt;
  logic [MAX_NODES-1:0]          visited_r, visited_nxt;
  logic                          rd_vld_r;
  logic                          pend_vld_r, pend_vld_nxt;
  mstp_pkg::node_pair_t          pend_pair_r, pend_pair_nxt;
  logic signed [WEIGHT_BITS-1:0] pend_w_r, pend_w_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [NW-1:0]                 out_from_r, out_from_nxt;
  logic [NW-1:0]                 out_to_r, out_to_nxt;
  logic signed [WEIGHT_BITS-1:0] out_w_r, out_w_nxt;
  logic                          out_ev_r, out_ev_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_drop_r, out_drop_nxt;

  logic [NW-1:0]                 lim;
  logic                          in_fire, edge_ok, root_ok, out_free;
  logic                          wr_en, rd_en, best_clr;
  logic [NW-1:0]                 st_a, st_b;
  logic signed [WEIGHT_BITS-1:0] st_w;
  logic [NW-1:0]                 a_m1, b_m1, root_m1, best_to_m1;
  logic                          a_in, b_in, va, vb;
  logic                          cand_vld;
  mstp_pkg::node_pair_t          cand_pair;
  mstp_pkg::best_stat_t          best;
  logic signed [WEIGHT_BITS-1:0] best_w;

  assign lim      = (node_total_r > MAX_NODE_VAL) ? MAX_NODE_VAL : node_total_r;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign edge_ok  = (in_end_a != '0) && (in_end_b != '0) && (in_end_a <= lim) &&
                    (in_end_b <= lim) && (fill_r != FW'(MAX_EDGES));
  assign root_ok  = (root_node_r != '0) && (root_node_r <= lim);
  assign out_free = !out_valid_r || out_ready;
  assign wr_en    = in_fire && edge_ok;
  assign cfg_ready = 1'b1;

  mstp_edge_store #(
    .DEPTH       (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_a    (in_end_a),
    .wr_b    (in_end_b),
    .wr_w    (in_edge_weight),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt_r[AW-1:0]),
    .rd_a    (st_a),
    .rd_b    (st_b),
    .rd_w    (st_w)
  );

  // candidate qualification against the visited map
  always_comb begin
    a_m1       = st_a - NODE_ONE;
    b_m1       = st_b - NODE_ONE;
    root_m1    = root_node_r - NODE_ONE;
    best_to_m1 = best.pair.to_node - NODE_ONE;
    a_in       = (st_a != '0) && (st_a <= lim);
    b_in       = (st_b != '0) && (st_b <= lim);
    va         = visited_r[a_m1[IW-1:0]];
    vb         = visited_r[b_m1[IW-1:0]];
    cand_vld   = rd_vld_r && a_in && b_in && (va != vb);
    cand_pair.from_node = va ? st_a : st_b;
    cand_pair.to_node   = va ? st_b : st_a;
  end

  mstp_min_unit #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_min (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (best_clr),
    .cand_vld  (cand_vld),
    .cand_pair (cand_pair),
    .cand_w    (st_w),
    .best      (best),
    .best_w    (best_w)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    scan_cnt_nxt  = scan_cnt_r;
    drop_nxt      = drop_r;
    visited_nxt   = visited_r;
    pend_vld_nxt  = pend_vld_r;
    pend_pair_nxt = pend_pair_r;
    pend_w_nxt    = pend_w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_w_nxt     = out_w_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    rd_en         = 1'b0;
    best_clr      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (edge_ok) begin
            fill_nxt = fill_r + FW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_edge) begin
            pend_vld_nxt = 1'b0;
            best_clr     = 1'b1;
            scan_cnt_nxt = '0;
            if (root_ok) begin
              visited_nxt[root_m1[IW-1:0]] = 1'b1;
              state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_DECIDE;
            end
          end
        end
      end
      ST_SCAN: begin
        best_clr = (scan_cnt_r == '0);
        if (scan_cnt_r != fill_r) begin
          rd_en        = 1'b1;
          scan_cnt_nxt = scan_cnt_r + FW'(1);
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (best.found) begin
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_from_nxt  = pend_pair_r.from_node;
              out_to_nxt    = pend_pair_r.to_node;
              out_w_nxt     = pend_w_r;
              out_ev_nxt    = 1'b1;
              out_last_nxt  = 1'b0;
              out_drop_nxt  = drop_r;
            end
            pend_vld_nxt  = 1'b1;
            pend_pair_nxt = best.pair;
            pend_w_nxt    = best_w;
            visited_nxt[best_to_m1[IW-1:0]] = 1'b1;
            scan_cnt_nxt  = '0;
            state_nxt     = ST_SCAN;
          end
        end else if (out_free) begin
          // no candidate left: the held edge, or an empty marker, closes the run
          out_valid_nxt = 1'b1;
          out_from_nxt  = pend_vld_r ? pend_pair_r.from_node : '0;
          out_to_nxt    = pend_vld_r ? pend_pair_r.to_node : '0;
          out_w_nxt     = pend_vld_r ? pend_w_r : '0;
          out_ev_nxt    = pend_vld_r;
          out_last_nxt  = 1'b1;
          out_drop_nxt  = drop_r;
          fill_nxt      = '0;
          drop_nxt      = 1'b0;
          visited_nxt   = '0;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      scan_cnt_r   <= '0;
      drop_r       <= 1'b0;
      visited_r    <= '0;
      rd_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      node_total_r <= mstp_pkg::NODE_TOTAL_RST;
      root_node_r  <= mstp_pkg::ROOT_NODE_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      drop_r      <= drop_nxt;
      visited_r   <= visited_nxt;
      rd_vld_r    <= rd_en;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mstp_pkg::CFG_NODE_TOTAL: node_total_r <= cfg_data;
          mstp_pkg::CFG_ROOT_NODE:  root_node_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_pair_r <= pend_pair_nxt;
    pend_w_r    <= pend_w_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_w_r     <= out_w_nxt;
    out_ev_r    <= out_ev_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_from_node     = out_from_r;
  assign out_to_node       = out_to_r;
  assign out_tree_weight   = out_w_r;
  assign out_edge_valid    = out_ev_r;
  assign out_last_result   = out_last_r;
  assign out_dropped_edges = out_drop_r;

  `MSTP_CHECK(a_fill_bound, fill_r <= FW'(MAX_EDGES), "edge fill beyond store capacity")
  `MSTP_IMPLY(a_idle_clear, state_r == ST_IDLE, visited_r == '0, "visited map not clear when idle")
  `MSTP_IMPLY(a_best_fresh, (state_r == ST_DECIDE) && best.found, !visited_r[best_to_m1[IW-1:0]], "chosen edge leads to a visited node")

endmodule

// ===== verif/minimum_spanning_tree_prim_tb.sv =====
// Self-checking testbench for the Prim minimum spanning tree engine.
module minimum_spanning_tree_prim_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES    = 64;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;
  localparam int RESET_CYCLES = 6;
  localparam int QUIET_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_EDGES = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SHOW_LIMIT   = 10;

  typedef logic [mstp_pkg::NODE_W-1:0]   node_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  typedef struct {
    node_t   end_a;
    node_t   end_b;
    weight_t weight;
    logic    last;
  } graph_edge_t;

  typedef struct {
    node_t   from_node;
    node_t   to_node;
    weight_t weight;
    logic    edge_valid;
    logic    last_result;
    logic    dropped;
  } tree_edge_t;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  node_t                          in_end_a       = '0;
  node_t                          in_end_b       = '0;
  weight_t                        in_edge_weight = '0;
  logic                           in_last_edge   = 1'b0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  node_t                          out_from_node;
  node_t                          out_to_node;
  weight_t                        out_tree_weight;
  logic                           out_edge_valid;
  logic                           out_last_result;
  logic                           out_dropped_edges;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [mstp_pkg::CFG_IDX_W-1:0] cfg_index      = mstp_pkg::CFG_NODE_TOTAL;
  node_t                          cfg_data       = '0;

  // mirror of the engine state
  node_t       node_total_q  = mstp_pkg::NODE_TOTAL_RST;
  node_t       root_node_q   = mstp_pkg::ROOT_NODE_RST;
  node_t       store_a [MAX_EDGES];
  node_t       store_b [MAX_EDGES];
  weight_t     store_w [MAX_EDGES];
  int          store_fill    = 0;
  logic        store_dropped = 1'b0;

  tree_edge_t  tree_edges_due [$];
  graph_edge_t edge_queue [$];
  graph_edge_t on_bus;
  int          feed_gap      = 0;
  int          drain_gap     = 0;
  bit          feed_steady   = 1'b0;
  bit          drain_steady  = 1'b0;
  bit          hold_req      = 1'b0;
  int          edges_sent    = 0;
  int          mismatches    = 0;
  int          cycles        = 0;

  minimum_spanning_tree_prim #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_end_a         (in_end_a),
    .in_end_b         (in_end_b),
    .in_edge_weight   (in_edge_weight),
    .in_last_edge     (in_last_edge),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_from_node    (out_from_node),
    .out_to_node      (out_to_node),
    .out_tree_weight  (out_tree_weight),
    .out_edge_valid   (out_edge_valid),
    .out_last_result  (out_last_result),
    .out_dropped_edges(out_dropped_edges),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Store one edge; on the last edge grow the tree and queue its edges.
  function automatic void grow_tree(graph_edge_t e);
    int         lim;
    int         picked = 0;
    bit         visited [MAX_NODES+1];
    bit         found;
    weight_t    bw;
    int         bf, bt, f, t, ea, eb;
    tree_edge_t r;
    lim = (node_total_q > MAX_NODES) ? MAX_NODES : int'(node_total_q);
    if (e.end_a == 0 || e.end_b == 0 || e.end_a > lim || e.end_b > lim ||
        store_fill >= MAX_EDGES) begin
      store_dropped = 1'b1;
    end else begin
      store_a[store_fill] = e.end_a;
      store_b[store_fill] = e.end_b;
      store_w[store_fill] = e.weight;
      store_fill++;
    end
    if (!e.last) return;
    if (root_node_q >= 1 && root_node_q <= lim) begin
      visited[root_node_q] = 1'b1;
      while (picked < MAX_NODES - 1) begin
        found = 1'b0;
        bw = '0;
        bf = 0;
        bt = 0;
        for (int i = 0; i < store_fill; i++) begin
          ea = store_a[i];
          eb = store_b[i];
          if (ea == 0 || eb == 0 || ea > lim || eb > lim) continue;
          if (visited[ea] && !visited[eb]) begin
            f = ea;
            t = eb;
          end else if (visited[eb] && !visited[ea]) begin
            f = eb;
            t = ea;
          end else begin
            continue;
          end
          if (!found || store_w[i] < bw ||
              (store_w[i] == bw && (f < bf || (f == bf && t < bt)))) begin
            found = 1'b1;
            bw = store_w[i];
            bf = f;
            bt = t;
          end
        end
        if (!found) break;
        visited[bt] = 1'b1;
        r.from_node   = node_t'(bf);
        r.to_node     = node_t'(bt);
        r.weight      = bw;
        r.edge_valid  = 1'b1;
        r.last_result = 1'b0;
        r.dropped     = store_dropped;
        tree_edges_due = {tree_edges_due, r};
        picked++;
      end
    end
    if (picked == 0) begin
      // done marker
      r.from_node   = '0;
      r.to_node     = '0;
      r.weight      = '0;
      r.edge_valid  = 1'b0;
      r.last_result = 1'b0;
      r.dropped     = store_dropped;
      tree_edges_due = {tree_edges_due, r};
    end
    tree_edges_due[tree_edges_due.size() - 1].last_result = 1'b1;
    store_fill = 0;
    store_dropped = 1'b0;
  endfunction

  task automatic check_tree_edge();
    tree_edge_t want;
    if (tree_edges_due.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("unexpected result: %0d->%0d w=%0d valid=%0b last=%0b drop=%0b",
                 out_from_node, out_to_node, out_tree_weight, out_edge_valid,
                 out_last_result, out_dropped_edges);
    end else begin
      want = tree_edges_due.pop_front();
      if (out_from_node !== want.from_node || out_to_node !== want.to_node ||
          out_tree_weight !== want.weight || out_edge_valid !== want.edge_valid ||
          out_last_result !== want.last_result || out_dropped_edges !== want.dropped) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display({"mismatch: expected %0d->%0d w=%0d valid=%0b last=%0b drop=%0b,",
                    " got %0d->%0d w=%0d valid=%0b last=%0b drop=%0b"},
                   want.from_node, want.to_node, want.weight, want.edge_valid,
                   want.last_result, want.dropped, out_from_node, out_to_node,
                   out_tree_weight, out_edge_valid, out_last_result, out_dropped_edges);
      end
    end
  endtask

  // driver: edge transfers, prediction on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) grow_tree(on_bus);
      if (!in_valid || in_ready) begin
        if (feed_gap > 0) begin
          feed_gap <= feed_gap - 1;
          in_valid <= 1'b0;
        end else if (edge_queue.size() > 0) begin
          on_bus = edge_queue.pop_front();
          in_end_a       <= on_bus.end_a;
          in_end_b       <= on_bus.end_b;
          in_edge_weight <= on_bus.weight;
          in_last_edge   <= on_bus.last;
          in_valid       <= 1'b1;
          feed_gap       <= (feed_steady || $urandom_range(0, 2) != 0) ? 0 : idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result transfers and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_tree_edge();
      if (hold_req && out_valid) begin
        hold_req = 1'b0;
        drain_gap <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (drain_gap > 0) begin
        drain_gap <= drain_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!drain_steady && $urandom_range(0, 3) == 0) drain_gap <= idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_edge(input int a, input int b, input int w, input bit last);
    graph_edge_t g;
    g.end_a  = node_t'(a);
    g.end_b  = node_t'(b);
    g.weight = weight_t'(w);
    g.last   = last;
    edge_queue = {edge_queue, g};
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (edge_queue.size() != 0 || in_valid || tree_edges_due.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mstp_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= node_t'(val);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mstp_pkg::CFG_NODE_TOTAL) node_total_q = node_t'(val);
    else root_node_q = node_t'(val);
  endtask

  // Spanning tree over 1..span first, then random extra edges, shuffled.
  task automatic queue_graph(input int span, input int n_edges, input int bad_pct,
                             input bit close_weights);
    graph_edge_t g [$];
    graph_edge_t tmp;
    int          a, b, j;
    for (int k = 0; k < n_edges; k++) begin
      if (k < span - 1) begin
        a = k + 2;
        b = $urandom_range(1, k + 1);
      end else begin
        a = $urandom_range(1, span);
        b = $urandom_range(1, span);
      end
      if ($urandom_range(1, 100) <= bad_pct) begin
        if ($urandom_range(0, 1) == 0) a = 0;
        else b = $urandom_range(span + 1, 127);
      end
      if ($urandom_range(0, 1) == 0) begin
        j = a;
        a = b;
        b = j;
      end
      tmp.end_a  = node_t'(a);
      tmp.end_b  = node_t'(b);
      tmp.weight = close_weights ? weight_t'(int'($urandom_range(0, 4)) - 2)
                                 : weight_t'($urandom);
      tmp.last   = 1'b0;
      g = {g, tmp};
    end
    for (int k = g.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = g[k];
      g[k] = g[j];
      g[j] = tmp;
    end
    g[g.size() - 1].last = 1'b1;
    edge_queue = {edge_queue, g};
    edges_sent += g.size();
  endtask

  initial begin
    int nt, rt, span, n_edges, graphs;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, self loop, parallel edges, bad node numbers
    add_edge(1, 64, -32768, 0);
    add_edge(64, 2, 32767, 0);
    add_edge(2, 1, 0, 0);
    add_edge(3, 3, -5, 0);
    add_edge(2, 1, -1, 0);
    add_edge(0, 5, 1, 0);
    add_edge(65, 1, 1, 0);
    add_edge(127, 127, -1, 0);
    add_edge(1, 3, 100, 1);
    add_edge(1, 2, 7, 1);
    add_edge(3, 4, 5, 1);
    add_edge(0, 0, 0, 1);
    wait_idle();
    write_reg(mstp_pkg::CFG_NODE_TOTAL, 0);
    add_edge(1, 1, 3, 0);
    add_edge(1, 2, 3, 1);
    wait_idle();
    write_reg(mstp_pkg::CFG_NODE_TOTAL, 127);
    write_reg(mstp_pkg::CFG_ROOT_NODE, 64);
    add_edge(64, 63, 9, 0);
    add_edge(63, 1, 9, 1);
    wait_idle();
    write_reg(mstp_pkg::CFG_ROOT_NODE, 0);
    add_edge(1, 2, 1, 1);
    wait_idle();
    write_reg(mstp_pkg::CFG_NODE_TOTAL, 64);
    write_reg(mstp_pkg::CFG_ROOT_NODE, 1);
    add_edge(1, 10, 3, 0);
    add_edge(1, 2, 4, 0);
    wait_idle();
    // node 10 falls out of range while stored
    write_reg(mstp_pkg::CFG_NODE_TOTAL, 5);
    add_edge(2, 3, 9, 1);
    wait_idle();
    write_reg(mstp_pkg::CFG_ROOT_NODE, 9);
    add_edge(1, 2, 1, 1);
    wait_idle();

    // full-size tree with a long receiver hold, next graph queued behind it
    write_reg(mstp_pkg::CFG_NODE_TOTAL, 64);
    write_reg(mstp_pkg::CFG_ROOT_NODE, 1);
    hold_req = 1'b1;
    queue_graph(MAX_NODES, MAX_NODES + 5, 0, 0);
    queue_graph(8, 10, 5, 1);
    wait_idle();

    edges_sent = 0;
    while (edges_sent < RANDOM_EDGES) begin
      case ($urandom_range(0, 9))
        0:       nt = 0;
        1:       nt = 1;
        2:       nt = $urandom_range(65, 127);
        3:       nt = 64;
        default: nt = $urandom_range(2, 12);
      endcase
      span = (nt == 0) ? 4 : ((nt > MAX_NODES) ? MAX_NODES : nt);
      case ($urandom_range(0, 7))
        0:       rt = 0;
        1:       rt = span + 1;
        2:       rt = $urandom_range(0, 127);
        default: rt = $urandom_range(1, span);
      endcase
      write_reg(mstp_pkg::CFG_NODE_TOTAL, nt);
      write_reg(mstp_pkg::CFG_ROOT_NODE, rt);
      feed_steady  = ($urandom_range(0, 3) == 0);
      drain_steady = ($urandom_range(0, 3) == 0);
      graphs = $urandom_range(1, 3);
      for (int k = 0; k < graphs; k++) begin
        if (span == 1) n_edges = $urandom_range(1, 3);
        else if (span > 12) n_edges = $urandom_range(1, 20);
        else n_edges = $urandom_range(1, 2 * span);
        queue_graph(span, n_edges, ($urandom_range(0, 3) == 0) ? 30 : 3,
                    $urandom_range(0, 2) == 0);
      end
      wait_idle();
    end

    repeat (64) @(negedge clk);
    if (mismatches == 0 && tree_edges_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== minimum_spanning_tree_prim.f =====
+incdir+rtl/core
rtl/core/mstp_pkg.sv
rtl/core/mstp_edge_store.sv
rtl/core/mstp_min_unit.sv
rtl/core/minimum_spanning_tree_prim.sv
verif/minimum_spanning_tree_prim_tb.sv
